### sv/cgsl_pkg.sv
// Shared codes, widths and control/status structs for the clip grid slot and launch block.
`default_nettype none
package cgsl_pkg;

   localparam int CMD_W  = 3;
   localparam int IDX_W  = 5;
   localparam int DIM_W  = 6;
   localparam int ST_W   = 2;
   localparam int CSR_W  = 1;

   localparam logic [CMD_W-1:0] CMD_PLACE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TRIG   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ROW    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd5;

   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_NOSLOT = 2'd1;
   localparam logic [ST_W-1:0] ST_BADIDX = 2'd2;

   localparam logic [CSR_W-1:0] CSR_NUM_COLS = 1'b0;
   localparam logic [CSR_W-1:0] CSR_NUM_ROWS = 1'b1;

   localparam logic [DIM_W-1:0] MIN_DIM = 6'd12;

   typedef struct packed {
      logic accept;
      logic clear;
      logic fwd;
      logic bwd;
      logic grow;
      logic row;
      logic exec;
      logic ship;
   } dp_ctl_type;

   typedef struct packed {
      logic in_place;
      logic in_row_ok;
      logic fwd_hit;
      logic bwd_hit;
      logic scan_last;
      logic scan_zero;
      logic can_grow;
      logic clear_last;
      logic out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

### sv/clip_grid_slot_and_launch_core.sv
// Top level of the clip grid slot allocator and launcher.
// Remove, trigger cell, stop and query pass through an execute state, then the result state;
// trigger row visits every column from column 0 to the last; place reads one column word per
// cycle over a forward scan, then a backward scan to column 0, plus a grow step if it grows.
// One item at a time: the next is accepted in the cycle after the result is registered.
// Reset: synchronous; a clearing pass then zeroes the occupancy memory words of columns 0 to
// min(MAX_COLS,32)-1, req_ready stays low during it, configuration writes are taken throughout.
`default_nettype none
module clip_grid_slot_and_launch_core #(
   parameter int MAX_COLS = 32,
   parameter int MAX_ROWS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cgsl_pkg::CMD_W-1:0]    req_command,
   input  logic [cgsl_pkg::IDX_W-1:0]    req_column_index,
   input  logic [cgsl_pkg::IDX_W-1:0]    req_row_index,
   input  logic                          req_allow_grow,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cgsl_pkg::ST_W-1:0]     rsp_status,
   output logic [cgsl_pkg::IDX_W-1:0]    rsp_slot_column,
   output logic [cgsl_pkg::IDX_W-1:0]    rsp_slot_row,
   output logic                          rsp_grew,
   output logic                          rsp_cell_occupied,
   output logic                          rsp_column_playing,
   output logic [cgsl_pkg::IDX_W-1:0]    rsp_playing_row_out,
   output logic [cgsl_pkg::DIM_W-1:0]    rsp_row_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cgsl_pkg::CSR_W-1:0]    csr_index,
   input  logic [cgsl_pkg::DIM_W-1:0]    csr_data
);
   import cgsl_pkg::*;

   dp_ctl_type  ctl;
   dp_stat_type stat;

   cgsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   cgsl_dpath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_command         (req_command),
      .req_column_index    (req_column_index),
      .req_row_index       (req_row_index),
      .req_allow_grow      (req_allow_grow),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot_column     (rsp_slot_column),
      .rsp_slot_row        (rsp_slot_row),
      .rsp_grew            (rsp_grew),
      .rsp_cell_occupied   (rsp_cell_occupied),
      .rsp_column_playing  (rsp_column_playing),
      .rsp_playing_row_out (rsp_playing_row_out),
      .rsp_row_count       (rsp_row_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .ctl                 (ctl),
      .stat                (stat)
   );

endmodule
`default_nettype wire

### sv/cgsl_ctrl.sv
// Command sequencer: steps the datapath through clear, search, trigger and result phases.
`default_nettype none
module cgsl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cgsl_pkg::dp_stat_type   stat,
   output cgsl_pkg::dp_ctl_type    ctl
);
   import cgsl_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FWD   = 3'd2;
   localparam logic [2:0] S_BWD   = 3'd3;
   localparam logic [2:0] S_GROW  = 3'd4;
   localparam logic [2:0] S_ROW   = 3'd5;
   localparam logic [2:0] S_EXEC  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_CLEAR: begin
            ctl.clear = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.accept = 1'b1;
               if (stat.in_place)       state_in = S_FWD;
               else if (stat.in_row_ok) state_in = S_ROW;
               else                     state_in = S_EXEC;
            end
         end
         S_FWD: begin
            ctl.fwd = 1'b1;
            if (stat.fwd_hit)        state_in = S_DONE;
            else if (stat.scan_last) state_in = S_BWD;
         end
         S_BWD: begin
            ctl.bwd = 1'b1;
            if (stat.bwd_hit) begin
               state_in = S_DONE;
            end else if (stat.scan_zero) begin
               state_in = stat.can_grow ? S_GROW : S_DONE;
            end
         end
         S_GROW: begin
            ctl.grow = 1'b1;
            state_in = S_DONE;
         end
         S_ROW: begin
            ctl.row = 1'b1;
            if (stat.scan_last) state_in = S_DONE;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               ctl.ship = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

### sv/cgsl_dpath.sv
// Datapath: occupancy memory (one word per column), play markers, config and result registers.
`default_nettype none
module cgsl_dpath #(
   parameter int MAX_COLS = 32,
   parameter int MAX_ROWS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cgsl_pkg::CMD_W-1:0]    req_command,
   input  logic [cgsl_pkg::IDX_W-1:0]    req_column_index,
   input  logic [cgsl_pkg::IDX_W-1:0]    req_row_index,
   input  logic                          req_allow_grow,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cgsl_pkg::ST_W-1:0]     rsp_status,
   output logic [cgsl_pkg::IDX_W-1:0]    rsp_slot_column,
   output logic [cgsl_pkg::IDX_W-1:0]    rsp_slot_row,
   output logic                          rsp_grew,
   output logic                          rsp_cell_occupied,
   output logic                          rsp_column_playing,
   output logic [cgsl_pkg::IDX_W-1:0]    rsp_playing_row_out,
   output logic [cgsl_pkg::DIM_W-1:0]    rsp_row_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cgsl_pkg::CSR_W-1:0]    csr_index,
   input  logic [cgsl_pkg::DIM_W-1:0]    csr_data,
   input  cgsl_pkg::dp_ctl_type          ctl,
   output cgsl_pkg::dp_stat_type         stat
);
   import cgsl_pkg::*;

   localparam int COL_CAP = (MAX_COLS < 32) ? MAX_COLS : 32;
   localparam int ROW_CAP = (MAX_ROWS < 32) ? MAX_ROWS : 32;
   localparam int CAW     = $clog2(COL_CAP);
   localparam int RAW     = $clog2(ROW_CAP);
   localparam int DEPTH   = 1 << CAW;
   localparam int WW      = 1 << RAW;
   localparam logic [DIM_W-1:0] COL_CAP_D = DIM_W'(COL_CAP);
   localparam logic [DIM_W-1:0] ROW_CAP_D = DIM_W'(ROW_CAP);
   localparam logic [IDX_W-1:0] CLR_LAST  = IDX_W'(COL_CAP - 1);

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] cap);
      logic [DIM_W-1:0] t;
      t = (v < MIN_DIM) ? MIN_DIM : v;
      return (t > cap) ? cap : t;
   endfunction

   // storage
   logic [WW-1:0]     occ_mem [DEPTH];
   logic [WW-1:0]     rdata_ff;
   logic              pv_ff   [DEPTH];
   logic [IDX_W-1:0]  prow_ff [DEPTH];

   logic [DIM_W-1:0]  num_cols_ff, num_cols_in;
   logic [DIM_W-1:0]  rows_ff, rows_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic              grow_ff, grow_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  rep_col_ff, rep_col_in;
   logic [IDX_W-1:0]  rep_row_ff, rep_row_in;
   logic [ST_W-1:0]   rep_status_ff, rep_status_in;
   logic              rep_grew_ff, rep_grew_in;
   logic              rep_occ_ff, rep_occ_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [IDX_W-1:0]  rsp_row_ff, rsp_row_in;
   logic              rsp_grew_ff, rsp_grew_in;
   logic              rsp_occ_ff, rsp_occ_in;
   logic              rsp_play_ff, rsp_play_in;
   logic [IDX_W-1:0]  rsp_prow_ff, rsp_prow_in;
   logic [DIM_W-1:0]  rsp_count_ff, rsp_count_in;

   // control
   logic              mem_we;
   logic [WW-1:0]     mem_wdata;
   logic              pv_we, pv_wval, prow_we;

   logic [DIM_W-1:0]  cols_eff;
   logic [IDX_W-1:0]  cols_last, rows_last, c0_in, r0_in;
   logic [WW-1:0]     rowmask, fwd_free, bwd_free, row_bit;
   logic [RAW-1:0]    lo_idx, hi_idx;
   logic [CAW-1:0]    sidx;
   logic              at_start, cur_bit, cell_in, col_in, col_play;

   assign cols_eff  = clamp_dim(num_cols_ff, COL_CAP_D);
   assign cols_last = IDX_W'(cols_eff - 6'd1);
   assign rows_last = IDX_W'(rows_ff - 6'd1);
   assign c0_in     = ({1'b0, req_column_index} > {1'b0, cols_last}) ? cols_last
                                                                     : req_column_index;
   assign r0_in     = ({1'b0, req_row_index} > {1'b0, rows_last}) ? rows_last : req_row_index;
   assign sidx      = scan_ff[CAW-1:0];
   assign at_start  = (scan_ff == rep_col_ff);
   assign row_bit   = WW'(1) << rep_row_ff[RAW-1:0];
   assign cur_bit   = rdata_ff[rep_row_ff[RAW-1:0]];
   assign col_in    = ({1'b0, rep_col_ff} < cols_eff);
   assign cell_in   = col_in && ({1'b0, rep_row_ff} < rows_ff);
   assign col_play  = col_in && pv_ff[sidx] && ({1'b0, prow_ff[sidx]} < rows_ff);

   // free-cell masks for the column word under scan
   always_comb begin
      lo_idx = '0;
      hi_idx = '0;
      for (int i = 0; i < WW; i++) begin
         rowmask[i]  = (DIM_W'(i) < rows_ff);
         fwd_free[i] = ~rdata_ff[i] & rowmask[i]
                       & (!at_start || (DIM_W'(i) >= {1'b0, rep_row_ff}));
         bwd_free[i] = ~rdata_ff[i] & rowmask[i]
                       & (!at_start || (DIM_W'(i) <= {1'b0, rep_row_ff}));
      end
      for (int i = WW - 1; i >= 0; i--) begin
         if (fwd_free[i]) lo_idx = RAW'(i);
      end
      for (int i = 0; i < WW; i++) begin
         if (bwd_free[i]) hi_idx = RAW'(i);
      end
   end

   always_comb begin
      stat.in_place   = (req_command == CMD_PLACE);
      stat.in_row_ok  = (req_command == CMD_ROW) && ({1'b0, req_row_index} < rows_ff);
      stat.fwd_hit    = |fwd_free;
      stat.bwd_hit    = |bwd_free;
      stat.scan_last  = (({1'b0, scan_ff} + 6'd1) == cols_eff);
      stat.scan_zero  = (scan_ff == '0);
      stat.can_grow   = grow_ff && (rows_ff < ROW_CAP_D);
      stat.clear_last = (scan_ff == CLR_LAST);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      num_cols_in   = num_cols_ff;
      rows_in       = rows_ff;
      cmd_in        = cmd_ff;
      grow_in       = grow_ff;
      scan_in       = scan_ff;
      rep_col_in    = rep_col_ff;
      rep_row_in    = rep_row_ff;
      rep_status_in = rep_status_ff;
      rep_grew_in   = rep_grew_ff;
      rep_occ_in    = rep_occ_ff;
      mem_we        = 1'b0;
      mem_wdata     = rdata_ff;
      pv_we         = 1'b0;
      pv_wval       = 1'b0;
      prow_we       = 1'b0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_grew_in   = rsp_grew_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_play_in   = rsp_play_ff;
      rsp_prow_in   = rsp_prow_ff;
      rsp_count_in  = rsp_count_ff;

      if (ctl.clear) begin
         mem_we    = 1'b1;
         mem_wdata = '0;
         scan_in   = stat.clear_last ? '0 : scan_ff + 5'd1;
      end

      if (ctl.accept) begin
         cmd_in        = req_command;
         grow_in       = req_allow_grow;
         rep_status_in = ST_OK;
         rep_grew_in   = 1'b0;
         rep_occ_in    = 1'b0;
         if (stat.in_place) begin
            rep_col_in = c0_in;
            rep_row_in = r0_in;
            scan_in    = c0_in;
         end else begin
            rep_col_in = req_column_index;
            rep_row_in = req_row_index;
            scan_in    = stat.in_row_ok ? '0 : req_column_index;
         end
      end

      if (ctl.fwd) begin
         if (stat.fwd_hit) begin
            mem_we     = 1'b1;
            mem_wdata  = rdata_ff | (WW'(1) << lo_idx);
            rep_col_in = scan_ff;
            rep_row_in = IDX_W'(lo_idx);
            rep_occ_in = 1'b1;
         end else begin
            scan_in = stat.scan_last ? rep_col_ff : scan_ff + 5'd1;
         end
      end

      if (ctl.bwd) begin
         if (stat.bwd_hit) begin
            mem_we     = 1'b1;
            mem_wdata  = rdata_ff | (WW'(1) << hi_idx);
            rep_col_in = scan_ff;
            rep_row_in = IDX_W'(hi_idx);
            rep_occ_in = 1'b1;
         end else if (stat.scan_zero) begin
            // whole active grid is full: either grow or report the clamped start
            scan_in    = rep_col_ff;
            rep_occ_in = 1'b1;
            if (!stat.can_grow) rep_status_in = ST_NOSLOT;
         end else begin
            scan_in = scan_ff - 5'd1;
         end
      end

      if (ctl.grow) begin
         mem_we      = 1'b1;
         mem_wdata   = rdata_ff | (WW'(1) << rows_ff[RAW-1:0]);
         rep_row_in  = IDX_W'(rows_ff);
         rows_in     = rows_ff + 6'd1;
         rep_grew_in = 1'b1;
         rep_occ_in  = 1'b1;
      end

      if (ctl.row) begin
         pv_we   = 1'b1;
         pv_wval = cur_bit;
         prow_we = cur_bit;
         if (at_start) rep_occ_in = cur_bit;
         scan_in = stat.scan_last ? rep_col_ff : scan_ff + 5'd1;
      end

      if (ctl.exec) begin
         rep_occ_in = cell_in && cur_bit;
         case (cmd_ff)
            CMD_REMOVE: begin
               if (cell_in) begin
                  mem_we     = 1'b1;
                  mem_wdata  = rdata_ff & ~row_bit;
                  rep_occ_in = 1'b0;
                  if (pv_ff[sidx] && (prow_ff[sidx] == rep_row_ff)) pv_we = 1'b1;
               end else begin
                  rep_status_in = ST_BADIDX;
               end
            end
            CMD_TRIG: begin
               if (!cell_in) begin
                  rep_status_in = ST_BADIDX;
               end else if (!cur_bit) begin
                  rep_status_in = ST_NOSLOT;
               end else begin
                  pv_we   = 1'b1;
                  pv_wval = 1'b1;
                  prow_we = 1'b1;
               end
            end
            CMD_STOP: begin
               if (col_in) pv_we = 1'b1;
               else        rep_status_in = ST_BADIDX;
            end
            CMD_QUERY: begin
               if (!cell_in) rep_status_in = ST_BADIDX;
            end
            default: rep_status_in = ST_BADIDX;
         endcase
      end

      if (ctl.ship) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = rep_status_ff;
         rsp_col_in    = rep_col_ff;
         rsp_row_in    = rep_row_ff;
         rsp_grew_in   = rep_grew_ff;
         rsp_occ_in    = rep_occ_ff;
         rsp_play_in   = col_play;
         rsp_prow_in   = col_play ? prow_ff[sidx] : '0;
         rsp_count_in  = rows_ff;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_COLS: num_cols_in = csr_data;
            CSR_NUM_ROWS: rows_in     = clamp_dim(csr_data, ROW_CAP_D);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) occ_mem[sidx] <= mem_wdata;
      rdata_ff <= occ_mem[scan_in[CAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) pv_ff[i] <= 1'b0;
      end else if (pv_we) begin
         pv_ff[sidx] <= pv_wval;
      end
      if (prow_we) prow_ff[sidx] <= rep_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff  <= MIN_DIM;
         rows_ff      <= clamp_dim(MIN_DIM, ROW_CAP_D);
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_cols_ff  <= num_cols_in;
         rows_ff      <= rows_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      grow_ff       <= grow_in;
      rep_col_ff    <= rep_col_in;
      rep_row_ff    <= rep_row_in;
      rep_status_ff <= rep_status_in;
      rep_grew_ff   <= rep_grew_in;
      rep_occ_ff    <= rep_occ_in;
      rsp_status_ff <= rsp_status_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_grew_ff   <= rsp_grew_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_play_ff   <= rsp_play_in;
      rsp_prow_ff   <= rsp_prow_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_column     = rsp_col_ff;
   assign rsp_slot_row        = rsp_row_ff;
   assign rsp_grew            = rsp_grew_ff;
   assign rsp_cell_occupied   = rsp_occ_ff;
   assign rsp_column_playing  = rsp_play_ff;
   assign rsp_playing_row_out = rsp_prow_ff;
   assign rsp_row_count       = rsp_count_ff;

endmodule
`default_nettype wire

### sv/cgsl_checker.sv
// Port-level checks for the clip grid core and the bind that attaches them.
`default_nettype none
module cgsl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic [cgsl_pkg::ST_W-1:0]     rsp_status,
   input logic [cgsl_pkg::IDX_W-1:0]    rsp_slot_row,
   input logic                          rsp_grew,
   input logic                          rsp_column_playing,
   input logic [cgsl_pkg::IDX_W-1:0]    rsp_playing_row_out,
   input logic [cgsl_pkg::DIM_W-1:0]    rsp_row_count
);
   import cgsl_pkg::*;

   // one item in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in flight");

   a_row_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_count >= MIN_DIM) && (rsp_row_count <= 6'd32))
      else $error("row count out of range");

   a_grow_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_grew) |->
         (rsp_status == ST_OK) && ({1'b0, rsp_slot_row} == (rsp_row_count - 6'd1)))
      else $error("grown slot is not the new last row");

   a_play_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_column_playing) |-> ({1'b0, rsp_playing_row_out} < rsp_row_count))
      else $error("playing row beyond rows in use");

endmodule

bind clip_grid_slot_and_launch_core cgsl_checker u_cgsl_checker (.*);
`default_nettype wire

### sim/clip_grid_slot_and_launch_checker.sv
`timescale 1ns / 100ps
// Checker for the clip grid core: mirrors grid and play markers, predicts each result, compares.
module clip_grid_slot_and_launch_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [cgsl_pkg::CMD_W-1:0]  req_command,
   input  logic [cgsl_pkg::IDX_W-1:0]  req_column_index,
   input  logic [cgsl_pkg::IDX_W-1:0]  req_row_index,
   input  logic                        req_allow_grow,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [cgsl_pkg::ST_W-1:0]   rsp_status,
   input  logic [cgsl_pkg::IDX_W-1:0]  rsp_slot_column,
   input  logic [cgsl_pkg::IDX_W-1:0]  rsp_slot_row,
   input  logic                        rsp_grew,
   input  logic                        rsp_cell_occupied,
   input  logic                        rsp_column_playing,
   input  logic [cgsl_pkg::IDX_W-1:0]  rsp_playing_row_out,
   input  logic [cgsl_pkg::DIM_W-1:0]  rsp_row_count,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [cgsl_pkg::CSR_W-1:0]  csr_index,
   input  logic [cgsl_pkg::DIM_W-1:0]  csr_data,
   output int                          fail_count,
   output int                          outstanding
);
   import cgsl_pkg::*;

   localparam int GRID_CAP   = 32;
   localparam int SHOW_LIMIT = 10;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [IDX_W-1:0] column;
      logic [IDX_W-1:0] row;
      logic             grew;
      logic             occupied;
      logic             playing;
      logic [IDX_W-1:0] playing_row;
      logic [DIM_W-1:0] row_count;
   } slot_result_t;

   logic             occupancy [GRID_CAP][GRID_CAP];
   logic             col_live  [GRID_CAP];
   logic [IDX_W-1:0] live_row  [GRID_CAP];
   logic [DIM_W-1:0] cols_reg;
   logic [DIM_W-1:0] rows_in_use;
   slot_result_t     expected_slots [$];
   slot_result_t     got;
   slot_result_t     want;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic int clamp_dim(input logic [DIM_W-1:0] v);
      int d;
      d = v;
      if (d < MIN_DIM) d = MIN_DIM;
      if (d > GRID_CAP) d = GRID_CAP;
      return d;
   endfunction

   function automatic logic cell_used(input int c, input int r);
      return c < clamp_dim(cols_reg) && r < rows_in_use && occupancy[c][r];
   endfunction

   // a marker beyond the current row count does not count as playing
   function automatic logic column_live(input int c);
      return c < clamp_dim(cols_reg) && col_live[c] && live_row[c] < rows_in_use;
   endfunction

   function automatic slot_result_t snapshot(input logic [ST_W-1:0] st, input int c,
                                             input int r, input logic grew);
      slot_result_t s;
      s.status      = st;
      s.column      = c[IDX_W-1:0];
      s.row         = r[IDX_W-1:0];
      s.grew        = grew;
      s.occupied    = cell_used(c, r);
      s.playing     = column_live(c);
      s.playing_row = s.playing ? live_row[c] : '0;
      s.row_count   = rows_in_use;
      return s;
   endfunction

   function automatic slot_result_t place_clip(input int col, input int row, input logic grow);
      int cols, rows, c, r, start, hit, k;
      cols  = clamp_dim(cols_reg);
      rows  = rows_in_use;
      c     = (col > cols - 1) ? cols - 1 : col;
      r     = (row > rows - 1) ? rows - 1 : row;
      start = c * rows + r;
      hit   = -1;
      // column-major scan forward from the start, then backward
      for (k = start; k < cols * rows && hit < 0; k++)
         if (!cell_used(k / rows, k % rows)) hit = k;
      for (k = start; k >= 0 && hit < 0; k--)
         if (!cell_used(k / rows, k % rows)) hit = k;
      if (hit >= 0) begin
         occupancy[hit / rows][hit % rows] = 1'b1;
         return snapshot(ST_OK, hit / rows, hit % rows, 1'b0);
      end
      if (!grow || rows_in_use >= GRID_CAP) return snapshot(ST_NOSLOT, c, r, 1'b0);
      rows_in_use = rows_in_use + 1'b1;
      occupancy[c][rows_in_use - 1] = 1'b1;
      return snapshot(ST_OK, c, rows_in_use - 1, 1'b1);
   endfunction

   function automatic slot_result_t apply_command(input logic [CMD_W-1:0] cmd, input int c,
                                                  input int r, input logic grow);
      slot_result_t res;
      logic         bad;
      logic         cell_in;
      int           cols;
      int           x;
      cols    = clamp_dim(cols_reg);
      cell_in = c < cols && r < rows_in_use;
      bad     = 1'b0;
      res     = '0;
      case (cmd)
         CMD_PLACE: res = place_clip(c, r, grow);
         CMD_REMOVE: begin
            if (!cell_in) begin
               bad = 1'b1;
            end else begin
               occupancy[c][r] = 1'b0;
               if (col_live[c] && live_row[c] == r) col_live[c] = 1'b0;
               res = snapshot(ST_OK, c, r, 1'b0);
            end
         end
         CMD_TRIG: begin
            if (!cell_in) begin
               bad = 1'b1;
            end else if (!cell_used(c, r)) begin
               res = snapshot(ST_NOSLOT, c, r, 1'b0);
            end else begin
               col_live[c] = 1'b1;
               live_row[c] = r[IDX_W-1:0];
               res = snapshot(ST_OK, c, r, 1'b0);
            end
         end
         CMD_ROW: begin
            if (r >= rows_in_use) begin
               bad = 1'b1;
            end else begin
               for (x = 0; x < cols; x++) begin
                  if (cell_used(x, r)) begin
                     col_live[x] = 1'b1;
                     live_row[x] = r[IDX_W-1:0];
                  end else begin
                     col_live[x] = 1'b0;
                  end
               end
               res = snapshot(ST_OK, c, r, 1'b0);
            end
         end
         CMD_STOP: begin
            if (c >= cols) begin
               bad = 1'b1;
            end else begin
               col_live[c] = 1'b0;
               res = snapshot(ST_OK, c, r, 1'b0);
            end
         end
         CMD_QUERY: begin
            if (!cell_in) bad = 1'b1;
            else res = snapshot(ST_OK, c, r, 1'b0);
         end
         default: bad = 1'b1;
      endcase
      if (bad) res = snapshot(ST_BADIDX, c, r, 1'b0);
      return res;
   endfunction

   function automatic string describe(input slot_result_t s);
      return $sformatf("st=%0d col=%0d row=%0d grew=%0b occ=%0b play=%0b prow=%0d rows=%0d",
                       s.status, s.column, s.row, s.grew, s.occupied, s.playing,
                       s.playing_row, s.row_count);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GRID_CAP; i++) begin
            for (int j = 0; j < GRID_CAP; j++) occupancy[i][j] = 1'b0;
            col_live[i] = 1'b0;
            live_row[i] = '0;
         end
         cols_reg    = MIN_DIM;
         rows_in_use = MIN_DIM;
         expected_slots.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUM_COLS) cols_reg = csr_data;
            else rows_in_use = DIM_W'(clamp_dim(csr_data));
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_slot_column, rsp_slot_row, rsp_grew, rsp_cell_occupied,
                   rsp_column_playing, rsp_playing_row_out, rsp_row_count};
            if (expected_slots.size() == 0) begin
               if (fail_count < SHOW_LIMIT)
                  $display("%0t: result with no command outstanding: %s", $time, describe(got));
               fail_count++;
            end else begin
               want = expected_slots.pop_front();
               if (got !== want) begin
                  if (fail_count < SHOW_LIMIT) begin
                     $display("%0t: result mismatch", $time);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(got));
                  end
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_slots.push_back(apply_command(req_command, req_column_index,
                                                   req_row_index, req_allow_grow));
      end
      outstanding = expected_slots.size();
   end

endmodule

### sim/clip_grid_slot_and_launch_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the clip grid core: clock, reset, command and register stimulus, verdict.
module clip_grid_slot_and_launch_core_test;
   import cgsl_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int STALL_AT       = 900;
   localparam int STALL_CYCLES   = 400;
   localparam int DRAIN_CYCLES   = 100;

   logic              clock              = 1'b0;
   logic              reset              = 1'b1;
   logic              req_valid          = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command        = '0;
   logic [IDX_W-1:0]  req_column_index   = '0;
   logic [IDX_W-1:0]  req_row_index      = '0;
   logic              req_allow_grow     = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready          = 1'b0;
   logic [ST_W-1:0]   rsp_status;
   logic [IDX_W-1:0]  rsp_slot_column;
   logic [IDX_W-1:0]  rsp_slot_row;
   logic              rsp_grew;
   logic              rsp_cell_occupied;
   logic              rsp_column_playing;
   logic [IDX_W-1:0]  rsp_playing_row_out;
   logic [DIM_W-1:0]  rsp_row_count;
   logic              csr_valid          = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index          = '0;
   logic [DIM_W-1:0]  csr_data           = '0;

   int   fail_count;
   int   outstanding;
   int   sent  = 0;
   int   quiet = 0;
   logic calm  = 1'b0;
   logic held  = 1'b0;

   clip_grid_slot_and_launch_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_column_index    (req_column_index),
      .req_row_index       (req_row_index),
      .req_allow_grow      (req_allow_grow),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot_column     (rsp_slot_column),
      .rsp_slot_row        (rsp_slot_row),
      .rsp_grew            (rsp_grew),
      .rsp_cell_occupied   (rsp_cell_occupied),
      .rsp_column_playing  (rsp_column_playing),
      .rsp_playing_row_out (rsp_playing_row_out),
      .rsp_row_count       (rsp_row_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   clip_grid_slot_and_launch_checker grid_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_column_index    (req_column_index),
      .req_row_index       (req_row_index),
      .req_allow_grow      (req_allow_grow),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot_column     (rsp_slot_column),
      .rsp_slot_row        (rsp_slot_row),
      .rsp_grew            (rsp_grew),
      .rsp_cell_occupied   (rsp_cell_occupied),
      .rsp_column_playing  (rsp_column_playing),
      .rsp_playing_row_out (rsp_playing_row_out),
      .rsp_row_count       (rsp_row_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .fail_count          (fail_count),
      .outstanding         (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // result side: random back-pressure, plus one long hold-off that fills the block
   initial begin
      forever begin
         @(posedge clock);
         if (!held && sent >= STALL_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 21);
      end
   end

   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int col, input int row,
                           input logic grow);
      if (!calm && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_column_index <= col[IDX_W-1:0];
      req_row_index    <= row[IDX_W-1:0];
      req_allow_grow   <= grow;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // drop valid and wait until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [DIM_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
      settle();
      write_reg(CSR_NUM_COLS, cols);
      write_reg(CSR_NUM_ROWS, rows);
      csr_valid <= 1'b0;
   endtask

   task automatic random_burst(input int count, input int place_pct, input int col_span,
                               input int row_span);
      logic [CMD_W-1:0] ops [5];
      logic [CMD_W-1:0] cmd;
      int               pick;
      int               col;
      int               row;
      ops = '{CMD_REMOVE, CMD_TRIG, CMD_ROW, CMD_STOP, CMD_QUERY};
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < place_pct) cmd = CMD_PLACE;
         else if (pick < 97) cmd = ops[$urandom_range(0, 4)];
         else cmd = $urandom_range(0, 1) ? CMD_SPARE_B : CMD_SPARE_A;
         col = ($urandom_range(0, 99) < 80) ? $urandom_range(0, col_span - 1)
                                             : $urandom_range(0, 31);
         row = ($urandom_range(0, 99) < 80) ? $urandom_range(0, row_span - 1)
                                             : $urandom_range(0, 31);
         send_cmd(cmd, col, row, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // below-minimum values clamp to a 12 x 12 grid
      configure(6'd0, 6'd5);
      send_cmd(CMD_QUERY,   0,  0,  1'b0);
      send_cmd(CMD_TRIG,    3,  4,  1'b0);
      send_cmd(CMD_PLACE,   31, 31, 1'b0);
      send_cmd(CMD_PLACE,   31, 31, 1'b0);
      send_cmd(CMD_PLACE,   0,  0,  1'b0);
      send_cmd(CMD_TRIG,    0,  0,  1'b0);
      send_cmd(CMD_QUERY,   0,  0,  1'b0);
      send_cmd(CMD_ROW,     31, 0,  1'b0);
      send_cmd(CMD_PLACE,   0,  0,  1'b1);
      send_cmd(CMD_TRIG,    0,  1,  1'b0);
      send_cmd(CMD_REMOVE,  0,  1,  1'b0);
      send_cmd(CMD_QUERY,   0,  1,  1'b0);
      send_cmd(CMD_STOP,    31, 0,  1'b0);
      send_cmd(CMD_STOP,    0,  0,  1'b0);
      send_cmd(CMD_QUERY,   12, 0,  1'b0);
      send_cmd(CMD_REMOVE,  0,  12, 1'b0);
      send_cmd(CMD_ROW,     0,  12, 1'b0);
      send_cmd(CMD_ROW,     0,  31, 1'b1);
      send_cmd(CMD_SPARE_A, 5,  5,  1'b0);
      send_cmd(CMD_SPARE_B, 31, 31, 1'b1);
      send_cmd(CMD_PLACE,   5,  5,  1'b1);
      send_cmd(CMD_QUERY,   31, 31, 1'b0);
      send_cmd(CMD_TRIG,    11, 11, 1'b0);
      send_cmd(CMD_ROW,     20, 11, 1'b0);
      send_cmd(CMD_REMOVE,  11, 11, 1'b0);

      // mostly placements: fill the grid, then grow it
      random_burst(255, 80, 12, 14);
      // rows at the cap over a part-filled grid, driven to full
      configure(6'd12, 6'd32);
      random_burst(350, 85, 12, 32);
      // above-maximum values clamp to 32 x 32; second half runs without idling
      configure(6'd63, 6'd63);
      random_burst(100, 40, 32, 32);
      calm = 1'b1;
      random_burst(100, 40, 32, 32);
      calm = 1'b0;
      // shrink rows: stale cells above the row count get reused on grow
      configure(6'd20, 6'd12);
      random_burst(250, 80, 20, 16);
      configure(6'd32, 6'd0);
      random_burst(230, 50, 32, 14);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
